[hw/rtl/ihwl_pkg.sv]
// ----------------------------------------------------------------------------
// ihwl_pkg
// Shared types and constants of the Intel HEX word loader.
// ----------------------------------------------------------------------------
`default_nettype none

package ihwl_pkg;

	localparam int DEF_MAX_RECORD_BYTES = 64;
	localparam int MAX_RESULTS          = 32;
	localparam int RES_CNT_W            = $clog2(MAX_RESULTS + 1);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 1'b1;

	localparam logic [7:0] CHAR_COLON   = 8'h3a;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

	localparam logic [7:0] REC_TYPE_DATA = 8'h00;
	localparam logic [7:0] REC_TYPE_EOF  = 8'h01;

	typedef enum logic [1:0] {
		KIND_WORD = 2'd0,
		KIND_ERR  = 2'd1,
		KIND_EOF  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_WAIT   = 3'd0,
		PH_HEADER = 3'd1,
		PH_DATA   = 3'd2,
		PH_DONE   = 3'd3,
		PH_LONG   = 3'd4,
		PH_SKIP   = 3'd5
	} phase_t;

	typedef enum logic [3:0] {
		CS_IDLE  = 4'd0,
		CS_SCAN  = 4'd1,
		CS_RD_LO = 4'd2,
		CS_RD_HI = 4'd3,
		CS_CAP   = 4'd4,
		CS_FLUSH = 4'd5,
		CS_ERR   = 4'd6,
		CS_EOF   = 4'd7,
		CS_STOP  = 4'd8
	} ctrl_state_t;

	typedef struct packed {
		logic [7:0] char_in;
	} char_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] word_addr;
		logic [15:0] word_data;
		logic        last;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic  take;         // character transaction
		logic  scan_start;   // begin walking the buffered record
		logic  skip;         // step past a word that is not emitted
		logic  rd_hi;        // buffer read selects the high byte of the word
		logic  lo_cap;       // capture low byte from the buffer
		logic  commit;       // word assembled: retire held word, hold new one
		logic  flush;        // send held word as the last result
		logic  push_status;  // send error / end-of-file result
		kind_t status_kind;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic eol;
		logic rec_open;
		logic rec_ok;
		logic type_eof;
		logic type_data;
		logic scan_done;
		logic scan_hit;
		logic held_valid;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/ihwl_stream_if.sv]
// ----------------------------------------------------------------------------
// ihwl_stream_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihwl_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/intel_hex_word_loader.sv]
// ----------------------------------------------------------------------------
// intel_hex_word_loader
// Intel HEX text in, one character per transaction; 16-bit word writes,
// error and end-of-file results out. At the end of a good data record the
// sequencer walks the record word by word through the single read port of
// the byte buffer: a word outside the window or past the result limit is
// skipped in the scan state, an emitted word goes through the scan, low
// read, high read and capture states, and a flush state ends the walk.
// Characters are held off until the walk ends, which output stalls delay.
// A word is sent once the next emitted word is found or the walk ends, so
// its last flag is exact. An error or end-of-file result stops the block:
// characters are then taken and ignored until reset. Window registers must
// be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module intel_hex_word_loader import ihwl_pkg::*; #(
	parameter int MAX_RECORD_BYTES = DEF_MAX_RECORD_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ihwl_stream_if.sink           chars,
	ihwl_stream_if.source         results
);

	ctrl_cmd_t  cmd;
	dp_status_t st;
	logic       in_ready;
	logic       out_valid;
	result_t    out_data;
	char_t      in_data;

	assign in_data       = chars.data;
	assign chars.ready   = in_ready;
	assign results.valid = out_valid;
	assign results.data  = out_data;

	ihwl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	ihwl_datapath #(
		.MAX_RECORD_BYTES (MAX_RECORD_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_ready (results.ready),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

`default_nettype wire

[hw/rtl/ihwl_ram.sv]
// ----------------------------------------------------------------------------
// ihwl_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ihwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/ihwl_ctrl.sv]
// ----------------------------------------------------------------------------
// ihwl_ctrl
// Sequencer: accepts characters, then walks a finished record and
// schedules its word, error and end-of-file results.
// ----------------------------------------------------------------------------
`default_nettype none

module ihwl_ctrl import ihwl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= CS_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (in_valid && st.eol && st.rec_open) begin
					if (!st.rec_ok)
						state_d = CS_ERR;
					else if (st.type_eof)
						state_d = CS_EOF;
					else if (st.type_data)
						state_d = CS_SCAN;
				end
			end
			CS_SCAN: begin
				if (st.scan_done)
					state_d = CS_FLUSH;
				else if (st.scan_hit)
					state_d = CS_RD_LO;
			end
			CS_RD_LO: state_d = CS_RD_HI;
			CS_RD_HI: state_d = CS_CAP;
			CS_CAP: begin
				if (!st.held_valid || st.out_free)
					state_d = CS_SCAN;
			end
			CS_FLUSH: begin
				if (!st.held_valid || st.out_free)
					state_d = CS_IDLE;
			end
			CS_ERR, CS_EOF: begin
				if (st.out_free)
					state_d = CS_STOP;
			end
			CS_STOP: state_d = CS_STOP;
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd             = '0;
		cmd.status_kind = KIND_ERR;
		case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				cmd.scan_start = in_valid && st.eol && st.rec_open && st.rec_ok &&
					!st.type_eof && st.type_data;
			end
			CS_SCAN: begin
				cmd.skip = !st.scan_done && !st.scan_hit;
			end
			CS_RD_LO: ;
			CS_RD_HI: begin
				cmd.rd_hi  = 1'b1;
				cmd.lo_cap = 1'b1;
			end
			CS_CAP: begin
				// address held so the read data stays put while we wait
				cmd.rd_hi  = 1'b1;
				cmd.commit = !st.held_valid || st.out_free;
			end
			CS_FLUSH: begin
				cmd.flush = st.held_valid && st.out_free;
			end
			CS_ERR: begin
				cmd.push_status = st.out_free;
				cmd.status_kind = KIND_ERR;
			end
			CS_EOF: begin
				cmd.push_status = st.out_free;
				cmd.status_kind = KIND_EOF;
			end
			CS_STOP: begin
				// characters are drained and ignored until reset
				in_ready = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/ihwl_datapath.sv]
// ----------------------------------------------------------------------------
// ihwl_datapath
// Record decoder, data byte buffer, word walker, window registers and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ihwl_datapath import ihwl_pkg::*; #(
	parameter int MAX_RECORD_BYTES = DEF_MAX_RECORD_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  char_t                 in_data,
	output logic                  out_valid,
	output result_t               out_data,
	input  logic                  out_ready,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            st
);

	localparam int IDX_W = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;

	function automatic logic [3:0] digit_value(input logic [7:0] c);
		logic [7:0] v;
		v = c;
		if (c > CHAR_DIGIT_9)
			v = c - 8'd7;
		return v[3:0];
	endfunction

	// window registers
	logic [15:0] win_start_q, win_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= 16'h0000;
			win_end_q   <= 16'hffff;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_START: win_start_q <= cfg_data;
				CFG_WINDOW_END:   win_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// record decoder
	phase_t      phase_q;
	logic [3:0]  nib_hi_q;
	logic        toggle_q;
	logic [7:0]  byte_idx_q;
	logic [7:0]  rec_len_q;
	logic [15:0] rec_addr_q;
	logic [7:0]  rec_type_q;
	logic [7:0]  sum_q;
	logic [7:0]  chk_q;

	logic [7:0] c;
	logic [3:0] dv;
	logic [7:0] byte_val;
	logic       byte_done;
	logic       buf_we;
	logic [7:0] expect_sum;

	assign c          = in_data.char_in;
	assign dv         = digit_value(c);
	assign byte_val   = {nib_hi_q, dv};
	assign byte_done  = cmd.take && !st.eol && toggle_q &&
		(phase_q inside {PH_HEADER, PH_DATA, PH_DONE, PH_LONG});
	assign buf_we     = byte_done && (phase_q == PH_DATA) && (byte_idx_q < rec_len_q) &&
		(byte_idx_q < 8'(MAX_RECORD_BYTES));
	assign expect_sum = 8'h00 - sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT;
			nib_hi_q   <= '0;
			toggle_q   <= 1'b0;
			byte_idx_q <= '0;
			rec_len_q  <= '0;
			rec_addr_q <= '0;
			rec_type_q <= '0;
			sum_q      <= '0;
			chk_q      <= '0;
		end else if (cmd.take) begin
			if (st.eol) begin
				phase_q <= PH_WAIT;
			end else begin
				case (phase_q)
					PH_WAIT: begin
						if (c == CHAR_COLON) begin
							phase_q    <= PH_HEADER;
							nib_hi_q   <= '0;
							toggle_q   <= 1'b0;
							byte_idx_q <= '0;
							rec_len_q  <= '0;
							rec_addr_q <= '0;
							rec_type_q <= '0;
							sum_q      <= '0;
							chk_q      <= '0;
						end else begin
							phase_q <= PH_SKIP;
						end
					end
					PH_SKIP: ;
					default: begin
						if (!toggle_q) begin
							nib_hi_q <= dv;
							toggle_q <= 1'b1;
						end else begin
							toggle_q <= 1'b0;
							case (phase_q)
								PH_HEADER: begin
									sum_q <= sum_q + byte_val;
									case (byte_idx_q[1:0])
										2'd0: rec_len_q <= byte_val;
										2'd1: rec_addr_q <= {byte_val, 8'h00};
										2'd2: rec_addr_q[7:0] <= byte_val;
										default: rec_type_q <= byte_val;
									endcase
									if (byte_idx_q == 8'd3) begin
										phase_q    <= PH_DATA;
										byte_idx_q <= '0;
									end else begin
										byte_idx_q <= byte_idx_q + 8'd1;
									end
								end
								PH_DATA: begin
									if (byte_idx_q < rec_len_q) begin
										sum_q      <= sum_q + byte_val;
										byte_idx_q <= byte_idx_q + 8'd1;
									end else begin
										chk_q   <= byte_val;
										phase_q <= PH_DONE;
									end
								end
								PH_DONE: phase_q <= PH_LONG;
								default: ;
							endcase
						end
					end
				endcase
			end
		end
	end

	// data byte buffer
	logic [7:0]       buf_rdata;
	logic [7:0]       rd_byte;
	logic [IDX_W-1:0] buf_raddr;
	logic [6:0]       word_idx_q;

	assign rd_byte   = {word_idx_q, cmd.rd_hi};
	assign buf_raddr = rd_byte[IDX_W-1:0];

	ihwl_ram #(
		.WIDTH (8),
		.DEPTH (MAX_RECORD_BYTES)
	) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (byte_idx_q[IDX_W-1:0]),
		.wdata (byte_val),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	// word walker
	logic [15:0]          scan_addr_q;
	logic [RES_CNT_W-1:0] n_q;
	logic [7:0]           lo_q;
	logic                 held_valid_q;
	logic [15:0]          held_addr_q;
	logic [15:0]          held_data_q;
	logic                 in_window;

	assign in_window = (scan_addr_q >= win_start_q) && (scan_addr_q <= win_end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q  <= '0;
			word_idx_q   <= '0;
			n_q          <= '0;
			held_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				scan_addr_q  <= {1'b0, rec_addr_q[15:1]};
				word_idx_q   <= '0;
				n_q          <= '0;
				held_valid_q <= 1'b0;
			end else if (cmd.skip) begin
				scan_addr_q <= scan_addr_q + 16'd1;
				word_idx_q  <= word_idx_q + 7'd1;
			end else if (cmd.commit) begin
				scan_addr_q  <= scan_addr_q + 16'd1;
				word_idx_q   <= word_idx_q + 7'd1;
				n_q          <= n_q + RES_CNT_W'(1);
				held_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				held_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lo_cap)
			lo_q <= buf_rdata;
		if (cmd.commit) begin
			held_addr_q <= scan_addr_q;
			held_data_q <= {buf_rdata, lo_q};
		end
	end

	// output register
	logic    out_valid_q;
	result_t out_q;
	logic    push;

	assign push = (cmd.commit && held_valid_q) || cmd.flush || cmd.push_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (push)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push_status) begin
			out_q.kind      <= cmd.status_kind;
			out_q.word_addr <= '0;
			out_q.word_data <= '0;
			out_q.last      <= 1'b1;
		end else if (push) begin
			// a held word is known to be last only once the walk ends
			out_q.kind      <= KIND_WORD;
			out_q.word_addr <= held_addr_q;
			out_q.word_data <= held_data_q;
			out_q.last      <= cmd.flush;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status
	assign st.eol        = (c <= CHAR_SPACE);
	assign st.rec_open   = phase_q inside {PH_HEADER, PH_DATA, PH_DONE, PH_LONG};
	assign st.rec_ok     = (phase_q == PH_DONE) && !toggle_q &&
		(rec_len_q <= 8'(MAX_RECORD_BYTES)) && (chk_q == expect_sum);
	assign st.type_eof   = (rec_type_q == REC_TYPE_EOF);
	assign st.type_data  = (rec_type_q == REC_TYPE_DATA);
	assign st.scan_done  = (word_idx_q == rec_len_q[7:1]);
	assign st.scan_hit   = in_window && (n_q < RES_CNT_W'(MAX_RESULTS));
	assign st.held_valid = held_valid_q;
	assign st.out_free   = !out_valid_q || out_ready;

endmodule

`default_nettype wire
